>>> rtl/b64d_pkg.sv
package b64d_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned SextetW  = 6;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 16;

  localparam logic [CountW-1:0]  CountMax    = {CountW{1'b1}};
  localparam logic [SextetW-1:0] SextetPlus  = 6'd62;
  localparam logic [SextetW-1:0] SextetSlash = 6'd63;
  localparam logic [SextetW-1:0] SextetUpper = 6'd0;
  localparam logic [SextetW-1:0] SextetLower = 6'd26;
  localparam logic [SextetW-1:0] SextetDigit = 6'd52;

  // Queue between classifier and decode stage
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QAddrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Position of the next character within its 4-character group
  typedef enum logic [3:0] {
    POS_0 = 4'b0001,
    POS_1 = 4'b0010,
    POS_2 = 4'b0100,
    POS_3 = 4'b1000
  } pos_e;

  typedef struct packed {
    logic [SextetW-1:0] sextet;
    logic               invalid;
    logic               eom;
  } class_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic class_t classify(input logic [CharW-1:0] c, input logic eom);
    class_t r;
    r.sextet  = '0;
    r.invalid = 1'b0;
    r.eom     = eom;
    if (c inside {[8'h41:8'h5A]}) begin
      r.sextet = SextetUpper + SextetW'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.sextet = SextetLower + SextetW'(c - 8'h61);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.sextet = SextetDigit + SextetW'(c - 8'h30);
    end else if (c == 8'h2B) begin
      r.sextet = SextetPlus;
    end else if (c == 8'h2F) begin
      r.sextet = SextetSlash;
    end else begin
      r.invalid = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> rtl/b64d_if.sv
interface b64d_char_if;
  import b64d_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_message;

  modport source (output valid, char_code, end_of_message, input ready);
  modport sink   (input valid, char_code, end_of_message, output ready);
endinterface

interface b64d_res_if;
  import b64d_pkg::*;
  logic              valid;
  logic              ready;
  logic              byte_valid;
  logic [ByteW-1:0]  data_byte;
  logic              message_done;
  logic [CountW-1:0] byte_count;
  logic              stopped;

  modport source (output valid, byte_valid, data_byte, message_done, byte_count, stopped,
                  input ready);
  modport sink   (input valid, byte_valid, data_byte, message_done, byte_count, stopped,
                  output ready);
endinterface

>>> rtl/b64d_front.sv
module b64d_front (
  b64d_char_if.sink          char_i,
  input  b64d_pkg::q_stat_t  stat_i,
  output logic               push_o,
  output b64d_pkg::class_t   cls_o
);
  import b64d_pkg::*;

  assign char_i.ready = !stat_i.full;
  assign push_o       = char_i.valid && !stat_i.full;
  assign cls_o        = classify(char_i.char_code, char_i.end_of_message);

endmodule

>>> rtl/b64d_queue.sv
module b64d_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b64d_pkg::class_t   wdata_i,
  input  logic               pop_i,
  output b64d_pkg::class_t   rdata_o,
  output b64d_pkg::q_stat_t  stat_o
);
  import b64d_pkg::*;

  class_t            mem_q [QueueDepth];
  logic [QAddrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QAddrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QAddrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/b64d_back.sv
module b64d_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b64d_pkg::class_t   cls_i,
  input  b64d_pkg::q_stat_t  stat_i,
  output logic               pop_o,
  b64d_res_if.source         res_o
);
  import b64d_pkg::*;

  pos_e               pos_q, pos_d, pos_u;
  logic [SextetW-1:0] prev_q, prev_d, prev_u;
  logic               halt_q, halt_d, halt_u;
  logic [CountW-1:0]  total_q, total_d, total_u;

  logic               byte_v;
  logic [ByteW-1:0]   byte_b;

  logic               out_valid_q, out_valid_d;
  logic               out_bv_q, out_done_q, out_stop_q;
  logic [ByteW-1:0]   out_byte_q;
  logic [CountW-1:0]  out_cnt_q;

  assign pop_o = !stat_i.empty && (!out_valid_q || res_o.ready);

  // Decode step on the head request
  always_comb begin
    pos_u   = pos_q;
    prev_u  = prev_q;
    halt_u  = halt_q;
    total_u = total_q;
    byte_v  = 1'b0;
    byte_b  = '0;
    if (!halt_q) begin
      if (cls_i.invalid) begin
        halt_u = 1'b1;
      end else begin
        case (pos_q)
          POS_1: begin
            byte_v = 1'b1;
            byte_b = {prev_q, cls_i.sextet[5:4]};
          end
          POS_2: begin
            byte_v = 1'b1;
            byte_b = {prev_q[3:0], cls_i.sextet[5:2]};
          end
          POS_3: begin
            byte_v = 1'b1;
            byte_b = {prev_q[1:0], cls_i.sextet};
          end
          default: ;
        endcase
        prev_u = cls_i.sextet;
        pos_u  = pos_e'({pos_q[2:0], pos_q[3]});
        if (byte_v && total_q != CountMax) begin
          total_u = total_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    pos_d   = pos_q;
    prev_d  = prev_q;
    halt_d  = halt_q;
    total_d = total_q;
    if (pop_o) begin
      if (cls_i.eom) begin
        pos_d   = POS_0;
        prev_d  = '0;
        halt_d  = 1'b0;
        total_d = '0;
      end else begin
        pos_d   = pos_u;
        prev_d  = prev_u;
        halt_d  = halt_u;
        total_d = total_u;
      end
    end
  end

  assign out_valid_d = pop_o || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_0;
      prev_q      <= '0;
      halt_q      <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      prev_q      <= prev_d;
      halt_q      <= halt_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_bv_q   <= byte_v;
      out_byte_q <= byte_b;
      out_done_q <= cls_i.eom;
      out_cnt_q  <= total_u;
      out_stop_q <= halt_u;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.byte_valid   = out_bv_q;
  assign res_o.data_byte    = out_byte_q;
  assign res_o.message_done = out_done_q;
  assign res_o.byte_count   = out_cnt_q;
  assign res_o.stopped      = out_stop_q;

endmodule

>>> rtl/base64_stream_decoder.sv
// Streaming base64 decoder, standard alphabet.
// char_i carries one encoded character per request plus an end-of-message
// flag; res_o returns exactly one result per character: an optional decoded
// byte, the saturating byte count of the message so far and a stopped flag
// that rises at the first character outside the alphabet.
// A classifier maps each accepted character to its 6-bit value and writes it
// into a two-entry queue; the decode stage pops the queue, merges the value
// with the previous one and loads the output register.
// An accepted character is written into a queue entry and then, once the
// output register is free, decoded into it. Throughput: one character per
// cycle while res_o accepts, set by the decode step and the output register.
// When res_o stalls, the output register holds its result, the queue fills,
// and char_i.ready drops once both queue entries are taken.
// Reset clears the queue, the output valid and the group/count state; the
// result of an end-of-message character also returns that state to its reset values.
module base64_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64d_char_if.sink   char_i,
  b64d_res_if.source  res_o
);
  import b64d_pkg::*;

  class_t  cls_in, cls_head;
  q_stat_t q_stat;
  logic    push, pop;

  b64d_front u_front (
    .char_i (char_i),
    .stat_i (q_stat),
    .push_o (push),
    .cls_o  (cls_in)
  );

  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cls_in),
    .pop_i   (pop),
    .rdata_o (cls_head),
    .stat_o  (q_stat)
  );

  b64d_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cls_i  (cls_head),
    .stat_i (q_stat),
    .pop_o  (pop),
    .res_o  (res_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_byte_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.byte_valid) |-> !res_o.stopped)
    else $error("decoded byte after stop");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && $past(res_o.valid && res_o.ready)
     && !$past(res_o.message_done))
    |-> (res_o.byte_count >= $past(res_o.byte_count)))
    else $error("byte count went down within a message");

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && $past(res_o.valid && res_o.ready)
     && $past(res_o.stopped) && !$past(res_o.message_done))
    |-> res_o.stopped)
    else $error("stopped flag cleared within a message");

endmodule
